// ----- rtl/core/dsq_pkg.sv -----
// Shared types and constants of the delta sleep queue.
package dsq_pkg;

	// Upper bound on wake-ups handed out for one tick
	localparam int MAX_RESULTS = 16;

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_WITHDRAW = 2'd1,
		CMD_TICK     = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_IGNORED   = 3'd1,
		ST_FULL      = 3'd2,
		ST_WITHDRAWN = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_WOKEN     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_LEFT,
		OP_LEFT_SUB,
		OP_RIGHT,
		OP_RIGHT_ADD,
		OP_DEC
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_WALK,
		S_DEL_WALK,
		S_FINISH,
		S_TICK_DEC,
		S_TICK_WAKE
	} state_t;

endpackage

// ----- rtl/core/dsq_cell.sv -----
// One entry of the delta list: thread id and relative delta, shifted by neighbour.
module dsq_cell #(
	parameter int TIME_BITS = 16
) (
	input  logic                  clk,
	input  dsq_pkg::cell_op_t     op,
	input  logic [7:0]            new_id,
	input  logic [TIME_BITS-1:0]  new_delta,
	input  logic [7:0]            left_id,
	input  logic [TIME_BITS-1:0]  left_delta,
	input  logic [7:0]            right_id,
	input  logic [TIME_BITS-1:0]  right_delta,
	output logic [7:0]            id,
	output logic [TIME_BITS-1:0]  delta
);
	import dsq_pkg::*;

	logic [7:0]           id_q;
	logic [TIME_BITS-1:0] delta_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				id_q    <= new_id;
				delta_q <= new_delta;
			end
			OP_LEFT: begin
				id_q    <= left_id;
				delta_q <= left_delta;
			end
			// old occupant of the insert slot: its wait now counts from the new entry
			OP_LEFT_SUB: begin
				id_q    <= left_id;
				delta_q <= left_delta - new_delta;
			end
			OP_RIGHT: begin
				id_q    <= right_id;
				delta_q <= right_delta;
			end
			// removed entry hands its delta on to its successor
			OP_RIGHT_ADD: begin
				id_q    <= right_id;
				delta_q <= right_delta + delta_q;
			end
			OP_DEC: begin
				if (delta_q != '0) begin
					delta_q <= delta_q - TIME_BITS'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign id    = id_q;
	assign delta = delta_q;

endmodule

// ----- rtl/core/delta_sleep_queue.sv -----
// Delta-list sleep queue: top level with control unit and the row of entry cells.
// Entries sit in a row of cells in wake order, each holding a thread id and its wait
// relative to the entry before it. Add and withdraw walk the row from the head, one
// cell per clock, then shift the row by one place at the position reached; a withdraw
// shifts only where it found the thread. An ignored add, an add on a full queue and
// the unused code skip the walk. A tick gives one result transfer per woken thread;
// a tick on an empty queue, like one that wakes nobody, gives no result. Every result
// may wait for the output register to free up. Only one command is in progress at a
// time; the next one is taken in the cycle after the last result of an add or
// withdraw is loaded into the output register, and after that of a tick once the
// control unit has gone from its wake state back to idle. Each result carries last on
// the final transfer of its command.
module delta_sleep_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  thread_id,
	input  logic [15:0] sleep_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  woken_id,
	output logic        last
);
	import dsq_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);
	localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);

	state_t               state_q, state_nxt;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        pos_q;
	logic [NW-1:0]        n_q;
	status_t              st_q;
	logic [TIME_BITS-1:0] t_q;
	logic [7:0]           id_q;

	logic                 out_valid_q;
	status_t              status_q;
	logic [7:0]           woken_id_q;
	logic                 last_q;

	cell_op_t             ops [QUEUE_DEPTH];
	logic [7:0]           cell_id [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] cell_delta [QUEUE_DEPTH];

	logic                 accept_in;
	logic                 out_free;
	logic                 in_range;
	logic [7:0]           cur_id;
	logic [TIME_BITS-1:0] cur_delta;
	logic                 add_step;
	logic                 del_match;
	logic                 wake_ok;
	logic                 add_ignore;
	logic                 q_full;
	logic [31:0]          time_ext;
	logic [TIME_BITS-1:0] time_sat;

	logic                 ins_en, rem_en, pop_en, dec_en;
	logic                 out_load;
	status_t              out_status;
	logic [7:0]           out_id;
	logic                 out_last;

	// row of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [7:0]           l_id, r_id;
		logic [TIME_BITS-1:0] l_delta, r_delta;

		if (i == 0) begin : g_head
			assign l_id    = '0;
			assign l_delta = '0;
		end else begin : g_mid_l
			assign l_id    = cell_id[i-1];
			assign l_delta = cell_delta[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_id    = '0;
			assign r_delta = '0;
		end else begin : g_mid_r
			assign r_id    = cell_id[i+1];
			assign r_delta = cell_delta[i+1];
		end

		dsq_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk        (clk),
			.op         (ops[i]),
			.new_id     (id_q),
			.new_delta  (t_q),
			.left_id    (l_id),
			.left_delta (l_delta),
			.right_id   (r_id),
			.right_delta(r_delta),
			.id         (cell_id[i]),
			.delta      (cell_delta[i])
		);
	end

	assign accept_in = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_range  = pos_q < count_q;
	assign cur_id    = cell_id[pos_q[IW-1:0]];
	assign cur_delta = cell_delta[pos_q[IW-1:0]];
	assign add_step  = in_range && (t_q >= cur_delta);
	assign del_match = in_range && (cur_id == id_q);
	assign wake_ok   = (count_q != '0) && (cell_delta[0] == '0) &&
	                   (n_q < NW'(MAX_RESULTS));
	assign add_ignore = (thread_id == 8'd0) || (sleep_time == 16'd0);
	assign q_full     = count_q == CW'(QUEUE_DEPTH);
	assign time_ext   = 32'(sleep_time);
	assign time_sat   = (time_ext > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
	                                          : time_ext[TIME_BITS-1:0];

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept_in) begin
					unique case (cmd)
						CMD_ADD: begin
							if (add_ignore || q_full) begin
								state_nxt = S_FINISH;
							end else begin
								state_nxt = S_ADD_WALK;
							end
						end
						CMD_WITHDRAW: state_nxt = S_DEL_WALK;
						CMD_TICK: begin
							state_nxt = (count_q == '0) ? S_IDLE : S_TICK_DEC;
						end
						default: state_nxt = S_FINISH;
					endcase
				end
			end
			S_ADD_WALK: begin
				if (!add_step) begin
					state_nxt = S_FINISH;
				end
			end
			S_DEL_WALK: begin
				if (!in_range || del_match) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_TICK_DEC: state_nxt = S_TICK_WAKE;
			S_TICK_WAKE: begin
				if (!wake_ok) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs of the control unit
	always_comb begin
		int p;
		p          = int'(pos_q);
		in_stall   = state_q != S_IDLE;
		ins_en     = 1'b0;
		rem_en     = 1'b0;
		pop_en     = 1'b0;
		dec_en     = 1'b0;
		out_load   = 1'b0;
		out_status = st_q;
		out_id     = 8'd0;
		out_last   = 1'b1;
		unique case (state_q)
			S_ADD_WALK: ins_en = !add_step;
			S_DEL_WALK: rem_en = del_match;
			S_TICK_DEC: dec_en = 1'b1;
			S_TICK_WAKE: begin
				if (wake_ok && out_free) begin
					pop_en     = 1'b1;
					out_load   = 1'b1;
					out_status = ST_WOKEN;
					out_id     = cell_id[0];
					// last wake-up when nothing further would pop on this tick
					out_last   = (count_q == CW'(1)) || (cell_delta[1] != '0) ||
					             (n_q == NW'(MAX_RESULTS - 1));
				end
			end
			S_FINISH: out_load = out_free;
			default: begin
			end
		endcase

		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ops[i] = OP_HOLD;
			if (ins_en) begin
				if (i == p) begin
					ops[i] = OP_LOAD;
				end else if (i == p + 1) begin
					ops[i] = OP_LEFT_SUB;
				end else if (i > p + 1) begin
					ops[i] = OP_LEFT;
				end
			end else if (rem_en) begin
				if (i == p) begin
					ops[i] = OP_RIGHT_ADD;
				end else if (i > p) begin
					ops[i] = OP_RIGHT;
				end
			end else if (pop_en) begin
				ops[i] = OP_RIGHT;
			end else if (dec_en && i == 0) begin
				ops[i] = OP_DEC;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			n_q         <= '0;
			st_q        <= ST_IGNORED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						pos_q <= '0;
						n_q   <= '0;
						if (cmd == CMD_ADD && add_ignore) begin
							st_q <= ST_IGNORED;
						end else if (cmd == CMD_ADD) begin
							st_q <= ST_FULL;
						end else begin
							st_q <= ST_IGNORED;
						end
					end
				end
				S_ADD_WALK: begin
					if (add_step) begin
						pos_q <= pos_q + CW'(1);
					end else begin
						count_q <= count_q + CW'(1);
						st_q    <= ST_ADDED;
					end
				end
				S_DEL_WALK: begin
					if (del_match) begin
						count_q <= count_q - CW'(1);
						st_q    <= ST_WITHDRAWN;
					end else if (in_range) begin
						pos_q <= pos_q + CW'(1);
					end else begin
						st_q <= ST_NOT_FOUND;
					end
				end
				S_TICK_WAKE: begin
					if (pop_en) begin
						count_q <= count_q - CW'(1);
						n_q     <= n_q + NW'(1);
					end
				end
				default: begin
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept_in) begin
			id_q <= thread_id;
			t_q  <= time_sat;
		end else if (state_q == S_ADD_WALK && add_step) begin
			t_q <= t_q - cur_delta;
		end
		if (out_load) begin
			status_q   <= out_status;
			woken_id_q <= out_id;
			last_q     <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign woken_id  = woken_id_q;
	assign last      = last_q;

endmodule

// ----- tb/tb_delta_sleep_queue.sv -----
// Testbench for the delta sleep queue: table and random commands against a predictor.
module tb_delta_sleep_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import dsq_pkg::*;

	localparam int QDEPTH = 16;
	localparam int TBITS = 16;
	localparam int RANDOM_ITEMS = 120;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		status_t st;
		logic [7:0] id;
		logic last;
	} result_t;

	typedef struct {
		logic [1:0] c;
		logic [7:0] id;
		logic [15:0] t;
		bit typed;
		status_t st;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = CMD_ADD;
	logic [7:0] thread_id = 8'd0;
	logic [15:0] sleep_time = 16'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] woken_id;
	logic last;

	// sideband held alongside the payload: result typed in the table
	bit row_typed = 1'b0;
	status_t row_status = ST_ADDED;

	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	// predictor state
	logic [7:0] q_id [QDEPTH];
	logic [15:0] q_delta [QDEPTH];
	int q_count = 0;
	result_t step_results [$];

	result_t due_results [$];
	result_t head;
	logic [7:0] added_ids [$];
	int real_items = 0;
	int mismatches = 0;
	int stuck_cycles = 0;
	bit moved;

	row_t plan [23] = '{
		'{CMD_TICK, 8'd0, 16'd0, 1'b0, ST_ADDED},
		'{CMD_ADD, 8'd0, 16'd5, 1'b1, ST_IGNORED},
		'{CMD_ADD, 8'd9, 16'd0, 1'b1, ST_IGNORED},
		'{CMD_WITHDRAW, 8'd0, 16'd0, 1'b1, ST_NOT_FOUND},
		'{CMD_UNUSED, 8'hFF, 16'hFFFF, 1'b1, ST_IGNORED},
		'{CMD_ADD, 8'hFF, 16'hFFFF, 1'b1, ST_ADDED},
		'{CMD_ADD, 8'd1, 16'd1, 1'b1, ST_ADDED},
		'{CMD_ADD, 8'd2, 16'd1, 1'b1, ST_ADDED},
		'{CMD_ADD, 8'd2, 16'd3, 1'b1, ST_ADDED},
		'{CMD_ADD, 8'h80, 16'd2, 1'b1, ST_ADDED},
		'{CMD_WITHDRAW, 8'd2, 16'd0, 1'b1, ST_WITHDRAWN},
		'{CMD_WITHDRAW, 8'd77, 16'd0, 1'b1, ST_NOT_FOUND},
		'{CMD_TICK, 8'd0, 16'd0, 1'b0, ST_ADDED},
		'{CMD_TICK, 8'd0, 16'd0, 1'b0, ST_ADDED},
		'{CMD_TICK, 8'd0, 16'd0, 1'b0, ST_ADDED},
		'{CMD_WITHDRAW, 8'hFF, 16'd0, 1'b1, ST_WITHDRAWN},
		'{CMD_TICK, 8'd0, 16'd0, 1'b0, ST_ADDED},
		'{CMD_ADD, 8'hAA, 16'h5555, 1'b1, ST_ADDED},
		'{CMD_ADD, 8'h55, 16'hAAAA, 1'b1, ST_ADDED},
		'{CMD_UNUSED, 8'd0, 16'd0, 1'b1, ST_IGNORED},
		'{CMD_WITHDRAW, 8'h55, 16'd0, 1'b1, ST_WITHDRAWN},
		'{CMD_WITHDRAW, 8'hAA, 16'd0, 1'b1, ST_WITHDRAWN},
		'{CMD_WITHDRAW, 8'hAA, 16'd0, 1'b1, ST_NOT_FOUND}
	};

	delta_sleep_queue #(
		.QUEUE_DEPTH(QDEPTH),
		.TIME_BITS(TBITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.thread_id(thread_id),
		.sleep_time(sleep_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.woken_id(woken_id),
		.last(last)
	);

	always #6ns clk = ~clk;

	// close the gap at p; the following entries move one place towards the head
	function automatic void remove_at(input int p);
		for (int i = p; i + 1 < q_count; i++) begin
			q_id[i] = q_id[i + 1];
			q_delta[i] = q_delta[i + 1];
		end
		q_count--;
	endfunction

	function automatic void advance_queue(input logic [1:0] c, input logic [7:0] id,
			input logic [15:0] t);
		int pos;
		int woke;
		logic [15:0] rem;
		logic [15:0] gone;
		status_t st;
		step_results.delete();
		pos = 0;
		woke = 0;
		st = ST_IGNORED;
		case (c)
			CMD_ADD: begin
				if (t == 16'd0 || id == 8'd0)
					st = ST_IGNORED;
				else if (q_count >= QDEPTH)
					st = ST_FULL;
				else begin
					rem = t;
					while (pos < q_count && rem >= q_delta[pos]) begin
						rem -= q_delta[pos];
						pos++;
					end
					for (int i = q_count; i > pos; i--) begin
						q_id[i] = q_id[i - 1];
						q_delta[i] = q_delta[i - 1];
					end
					q_id[pos] = id;
					q_delta[pos] = rem;
					q_count++;
					if (pos + 1 < q_count)
						q_delta[pos + 1] -= rem;
					st = ST_ADDED;
				end
			end
			CMD_WITHDRAW: begin
				while (pos < q_count && q_id[pos] != id)
					pos++;
				if (pos >= q_count)
					st = ST_NOT_FOUND;
				else begin
					gone = q_delta[pos];
					remove_at(pos);
					if (pos < q_count)
						q_delta[pos] += gone;
					st = ST_WITHDRAWN;
				end
			end
			CMD_TICK: begin
				if (q_count > 0 && q_delta[0] != 16'd0)
					q_delta[0]--;
				while (q_count > 0 && q_delta[0] == 16'd0 && woke < MAX_RESULTS) begin
					step_results.push_back('{ST_WOKEN, q_id[0], 1'b0});
					remove_at(0);
					woke++;
				end
			end
			default: st = ST_IGNORED;
		endcase
		if (c != CMD_TICK)
			step_results.push_back('{st, 8'd0, 1'b0});
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input int want, input int got);
		if (mismatches < 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		mismatches++;
	endtask

	// results and acceptance both sampled on the pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (due_results.size() == 0)
					flag_mismatch("unexpected result status", -1, status);
				else begin
					head = due_results.pop_front();
					if (status !== head.st)
						flag_mismatch("status", head.st, status);
					if (woken_id !== head.id)
						flag_mismatch("woken_id", head.id, woken_id);
					if (last !== head.last)
						flag_mismatch("last", head.last, last);
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				advance_queue(cmd, thread_id, sleep_time);
				if (row_typed)
					due_results.push_back('{row_status, 8'd0, 1'b1});
				else
					foreach (step_results[i])
						due_results.push_back(step_results[i]);
			end
			if (moved)
				stuck_cycles = 0;
			else begin
				stuck_cycles++;
				if (stuck_cycles >= STUCK_LIMIT) begin
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off while the sender keeps offering
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0)
			hold_left--;
		else
			out_stall <= !calm && ($urandom_range(0, 99) < 7);
	end

	task automatic offer(input logic [1:0] c, input logic [7:0] id, input logic [15:0] t,
			input bit typed, input status_t st);
		in_valid <= 1'b1;
		cmd <= c;
		thread_id <= id;
		sleep_time <= t;
		row_typed <= typed;
		row_status <= st;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		if (c == CMD_ADD && id != 8'd0) begin
			added_ids.push_back(id);
			if (added_ids.size() > 24)
				void'(added_ids.pop_front());
		end
		if (!(c == CMD_UNUSED || (c == CMD_ADD && (id == 8'd0 || t == 16'd0))))
			real_items++;
		if (!calm && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// one add more than fits, all with short waits, then ticks to wake them in bulk
	task automatic fill_queue();
		repeat (QDEPTH + 1)
			offer(CMD_ADD, 8'($urandom_range(1, 255)), 16'($urandom_range(1, 2)), 1'b0,
				ST_ADDED);
		repeat (3)
			offer(CMD_TICK, 8'($urandom), 16'($urandom), 1'b0, ST_ADDED);
	endtask

	task automatic random_item();
		int pick;
		int r;
		logic [7:0] id;
		logic [15:0] t;
		pick = $urandom_range(0, 99);
		id = 8'($urandom_range(1, 255));
		r = $urandom_range(0, 99);
		if (r < 5)
			id = 8'd0;
		else if (r < 15)
			id = 8'($urandom_range(1, 6));
		r = $urandom_range(0, 99);
		if (r < 5)
			t = 16'd0;
		else if (r < 60)
			t = 16'($urandom_range(1, 4));
		else if (r < 85)
			t = 16'($urandom_range(1, 40));
		else
			t = 16'($urandom);
		if (pick < 45)
			offer(CMD_ADD, id, t, 1'b0, ST_ADDED);
		else if (pick < 65) begin
			if (added_ids.size() > 0 && $urandom_range(0, 3) != 0)
				id = added_ids[$urandom_range(0, added_ids.size() - 1)];
			offer(CMD_WITHDRAW, id, t, 1'b0, ST_ADDED);
		end else if (pick < 95)
			offer(CMD_TICK, id, t, 1'b0, ST_ADDED);
		else
			offer(CMD_UNUSED, id, t, 1'b0, ST_ADDED);
	endtask

	initial begin
		int start_items;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i])
			offer(plan[i].c, plan[i].id, plan[i].t, plan[i].typed, plan[i].st);
		start_items = real_items;
		hold_req <= 1'b1;
		fill_queue();
		while (real_items - start_items < RANDOM_ITEMS) begin
			calm <= (real_items - start_items >= 70 && real_items - start_items < 110);
			if ($urandom_range(0, 29) == 0)
				fill_queue();
			else
				random_item();
		end
		in_valid <= 1'b0;
		calm <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
